// File: hdl/image_mirror_frame_store_assert.svh
// Assertion macros for the image mirror frame store checker.
// Depends on nothing; included by the checker file.
`ifndef IMAGE_MIRROR_FRAME_STORE_ASSERT_SVH
`define IMAGE_MIRROR_FRAME_STORE_ASSERT_SVH

// clocked property, disabled while reset is asserted
`define IMFS_ASSERT_CLK(name, clk, rstn, prop, msg) \
  name: assert property (@(posedge clk) disable iff (!rstn) prop) \
    else $error(msg);

// clocked property, checked in reset as well
`define IMFS_ASSERT_ALWAYS(name, clk, prop, msg) \
  name: assert property (@(posedge clk) prop) \
    else $error(msg);

`endif

// File: hdl/imfs_pkg.sv
// Shared constants, codes and types of the image mirror frame store.
// No dependencies; imported by imfs_addr, the top level and the checker.
`default_nettype none

package imfs_pkg;

  localparam int MEM_BYTES    = 65536;
  localparam int MAX_DIM      = 256;
  localparam int MAX_CHANNELS = 4;

  localparam int ADDR_W  = $clog2(MEM_BYTES);
  localparam int DIM_W   = 9;
  localparam int CH_W    = 3;
  localparam int PIX_W   = 2 * DIM_W;
  localparam int VOL_W   = 2 * DIM_W + CH_W;
  localparam int BYTE_W  = 8;

  localparam int NUM_REGS  = 3;
  localparam int REG_IDX_W = 2;
  localparam int PADDR_W   = REG_IDX_W + 2;
  localparam int APB_DW    = 32;

  localparam logic [1:0] MODE_WRITE  = 2'd0;
  localparam logic [1:0] MODE_READ   = 2'd1;
  localparam logic [1:0] MODE_MIRROR = 2'd2;

  localparam logic AXIS_ROWS = 1'b0;
  localparam logic AXIS_COLS = 1'b1;

  localparam logic [REG_IDX_W-1:0] REG_ROWS  = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_COLS  = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_CHANS = 2'd2;

  typedef struct packed {
    logic [1:0]        mode;
    logic [7:0]        row_pos;
    logic [7:0]        col_pos;
    logic [1:0]        chan_pos;
    logic [BYTE_W-1:0] wr_value;
    logic              axis;
  } imfs_in_t;

  typedef struct packed {
    logic [BYTE_W-1:0] rd_value;
    logic              status;
  } imfs_out_t;

  typedef struct packed {
    logic [DIM_W-1:0] frame_rows;
    logic [DIM_W-1:0] frame_cols;
    logic [CH_W-1:0]  pixel_channels;
  } imfs_cfg_t;

  typedef struct packed {
    logic rows;
    logic cols;
  } imfs_flip_t;

  // access descriptor handed from the address pipeline to the control
  typedef struct packed {
    logic [1:0]        mode;
    logic              axis;
    logic [BYTE_W-1:0] wr_value;
    logic              frame_ok;
    logic              coord_ok;
    logic [ADDR_W-1:0] addr;
  } imfs_acc_t;

endpackage

`default_nettype wire

// File: hdl/imfs_ram.sv
// Generic single-port RAM with registered read data.
// No dependencies.
`default_nettype none

module imfs_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic                     re_i,
  input  logic [$clog2(DEPTH)-1:0] addr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];
  logic [WIDTH-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[addr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[addr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

`default_nettype wire

// File: hdl/imfs_addr.sv
// Address pipeline: range checks, mirror remap, row/column/channel address.
// Depends on imfs_pkg.
`default_nettype none

module imfs_addr
  import imfs_pkg::*;
(
  input  logic       clk_i,
  input  logic       load_i,
  input  imfs_in_t   item_i,
  input  imfs_cfg_t  cfg_i,
  input  imfs_flip_t flip_i,
  output imfs_acc_t  acc_o
);

  imfs_in_t         item_q;

  logic [DIM_W-1:0] row_ext;
  logic [DIM_W-1:0] col_ext;
  logic [CH_W-1:0]  chan_ext;
  logic             dims_ok_d, coord_ok_d;
  logic [DIM_W-1:0] prow_d, pcol_d;
  logic [PIX_W-1:0] area_d;

  logic             dims_ok_q, coord1_ok_q;
  logic [DIM_W-1:0] prow_q, pcol_q;
  logic [PIX_W-1:0] area_q;

  logic [PIX_W-1:0] pix_d;
  logic [VOL_W-1:0] vol;
  logic             frame_ok_d;

  logic [PIX_W-1:0] pix_q;
  logic             frame_ok_q, coord2_ok_q;

  logic [PIX_W+CH_W-1:0] addr_full;

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      item_q <= item_i;
    end
  end

  // stage 1: checks and remap
  always_comb begin
    row_ext  = {1'b0, item_q.row_pos};
    col_ext  = {1'b0, item_q.col_pos};
    chan_ext = {1'b0, item_q.chan_pos};
    dims_ok_d = (cfg_i.frame_rows != '0)
             && (32'(cfg_i.frame_rows) <= 32'(MAX_DIM))
             && (cfg_i.frame_cols != '0)
             && (32'(cfg_i.frame_cols) <= 32'(MAX_DIM))
             && (cfg_i.pixel_channels != '0)
             && (32'(cfg_i.pixel_channels) <= 32'(MAX_CHANNELS));
    coord_ok_d = (row_ext < cfg_i.frame_rows) && (col_ext < cfg_i.frame_cols)
              && (chan_ext < cfg_i.pixel_channels);
    prow_d = flip_i.rows ? (cfg_i.frame_rows - DIM_W'(1) - row_ext) : row_ext;
    pcol_d = flip_i.cols ? (cfg_i.frame_cols - DIM_W'(1) - col_ext) : col_ext;
    area_d = PIX_W'(cfg_i.frame_rows) * PIX_W'(cfg_i.frame_cols);
  end

  always_ff @(posedge clk_i) begin
    dims_ok_q   <= dims_ok_d;
    coord1_ok_q <= coord_ok_d;
    prow_q      <= prow_d;
    pcol_q      <= pcol_d;
    area_q      <= area_d;
  end

  // stage 2: pixel index and frame volume
  always_comb begin
    pix_d      = (PIX_W'(prow_q) * PIX_W'(cfg_i.frame_cols)) + PIX_W'(pcol_q);
    vol        = VOL_W'(area_q) * VOL_W'(cfg_i.pixel_channels);
    frame_ok_d = dims_ok_q && (32'(vol) <= 32'(MEM_BYTES));
  end

  always_ff @(posedge clk_i) begin
    pix_q       <= pix_d;
    frame_ok_q  <= frame_ok_d;
    coord2_ok_q <= coord1_ok_q;
  end

  // stage 3: byte address
  assign addr_full = (PIX_W+CH_W)'(pix_q) * (PIX_W+CH_W)'(cfg_i.pixel_channels)
                   + (PIX_W+CH_W)'(item_q.chan_pos);

  always_comb begin
    acc_o.mode     = item_q.mode;
    acc_o.axis     = item_q.axis;
    acc_o.wr_value = item_q.wr_value;
    acc_o.frame_ok = frame_ok_q;
    acc_o.coord_ok = coord2_ok_q;
    acc_o.addr     = addr_full[ADDR_W-1:0];
  end

endmodule

`default_nettype wire

// File: hdl/image_mirror_frame_store.sv
// Image mirror frame store top level: APB registers, control, pixel RAM.
// Depends on imfs_pkg, imfs_addr and imfs_ram.
//
// Usage:
//   Input channel (in_valid_i/in_ready_o/in_data_i) takes one transaction
//   per item: write a byte, read a byte, or toggle a mirror axis. Output
//   channel (out_valid_o/out_ready_i/out_data_o) returns exactly one result
//   per item: the byte read (zero otherwise) and an error status.
//   One item is in flight at a time: a new item is taken only in idle,
//   and the control walks it through the three-stage address pipeline
//   ahead of the RAM port before returning to idle.
//   The next item is taken while a finished result waits in the output
//   register; a stalled receiver holds the following item in its last
//   stage with the RAM read data kept until the output register frees.
//   Reset clears both mirror flags and sets rows, columns and channels to
//   1. The pixel RAM is not cleared; read only what was written.
//   The APB port (pready always high) must be written only while idle; the block itself does not enforce this.
`default_nettype none

module image_mirror_frame_store
  import imfs_pkg::*;
(
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  output logic               in_ready_o,
  input  imfs_in_t           in_data_i,
  output logic               out_valid_o,
  input  logic               out_ready_i,
  output imfs_out_t          out_data_o,
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  localparam logic [2:0] ST_IDLE  = 3'd0;
  localparam logic [2:0] ST_REMAP = 3'd1;
  localparam logic [2:0] ST_MUL   = 3'd2;
  localparam logic [2:0] ST_ADDR  = 3'd3;
  localparam logic [2:0] ST_MEM   = 3'd4;

  logic [2:0]        state_q, state_d;
  imfs_cfg_t         cfg_q, cfg_d;
  imfs_flip_t        flip_q, flip_d;
  logic              res_ok_q, res_ok_d;
  logic              res_rd_q, res_rd_d;
  logic              out_valid_q, out_valid_d;
  imfs_out_t         out_q, out_d;

  logic              in_hs;
  logic              cfg_wr;
  logic [REG_IDX_W-1:0] reg_idx;
  imfs_acc_t         acc;
  logic              acc_ok;
  logic              ram_we, ram_re;
  logic [BYTE_W-1:0] ram_rdata;
  logic              out_free;

  assign in_ready_o = (state_q == ST_IDLE);
  assign in_hs      = in_valid_i && in_ready_o;
  assign out_free   = !out_valid_q || out_ready_i;
  assign pready     = 1'b1;
  assign cfg_wr     = psel && penable && pwrite;
  assign reg_idx    = paddr[PADDR_W-1:2];

  imfs_addr u_addr (
    .clk_i  (clk_i),
    .load_i (in_hs),
    .item_i (in_data_i),
    .cfg_i  (cfg_q),
    .flip_i (flip_q),
    .acc_o  (acc)
  );

  imfs_ram #(
    .WIDTH (BYTE_W),
    .DEPTH (MEM_BYTES)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .re_i    (ram_re),
    .addr_i  (acc.addr),
    .wdata_i (acc.wr_value),
    .rdata_o (ram_rdata)
  );

  always_comb begin
    acc_ok = acc.frame_ok && ((acc.mode == MODE_MIRROR)
          || (((acc.mode == MODE_WRITE) || (acc.mode == MODE_READ)) && acc.coord_ok));
    ram_we = (state_q == ST_ADDR) && acc_ok && (acc.mode == MODE_WRITE);
    ram_re = (state_q == ST_ADDR) && acc_ok && (acc.mode == MODE_READ);
  end

  // registers and readback
  always_comb begin
    cfg_d = cfg_q;
    if (cfg_wr) begin
      unique case (reg_idx)
        REG_ROWS:  cfg_d.frame_rows     = pwdata[DIM_W-1:0];
        REG_COLS:  cfg_d.frame_cols     = pwdata[DIM_W-1:0];
        REG_CHANS: cfg_d.pixel_channels = pwdata[CH_W-1:0];
        default:   cfg_d = cfg_q;
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx)
      REG_ROWS:  prdata = APB_DW'(cfg_q.frame_rows);
      REG_COLS:  prdata = APB_DW'(cfg_q.frame_cols);
      REG_CHANS: prdata = APB_DW'(cfg_q.pixel_channels);
      default:   prdata = '0;
    endcase
  end

  always_comb begin
    state_d     = state_q;
    flip_d      = flip_q;
    res_ok_d    = res_ok_q;
    res_rd_d    = res_rd_q;
    out_valid_d = out_valid_q && !out_ready_i;
    out_d       = out_q;
    unique case (state_q)
      ST_IDLE: begin
        if (in_hs) begin
          state_d = ST_REMAP;
        end
      end
      ST_REMAP: state_d = ST_MUL;
      ST_MUL:   state_d = ST_ADDR;
      ST_ADDR: begin
        res_ok_d = acc_ok;
        res_rd_d = acc_ok && (acc.mode == MODE_READ);
        if (acc_ok && (acc.mode == MODE_MIRROR)) begin
          if (acc.axis == AXIS_ROWS) begin
            flip_d.rows = !flip_q.rows;
          end else begin
            flip_d.cols = !flip_q.cols;
          end
        end
        state_d = ST_MEM;
      end
      ST_MEM: begin
        if (out_free) begin
          out_valid_d     = 1'b1;
          out_d.rd_value  = res_rd_q ? ram_rdata : '0;
          out_d.status    = !res_ok_q;
          state_d         = ST_IDLE;
        end
      end
      default: state_d = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      flip_q      <= '0;
      out_valid_q <= 1'b0;
      cfg_q.frame_rows     <= DIM_W'(1);
      cfg_q.frame_cols     <= DIM_W'(1);
      cfg_q.pixel_channels <= CH_W'(1);
    end else begin
      state_q     <= state_d;
      flip_q      <= flip_d;
      out_valid_q <= out_valid_d;
      cfg_q       <= cfg_d;
    end
  end

  always_ff @(posedge clk_i) begin
    res_ok_q <= res_ok_d;
    res_rd_q <= res_rd_d;
    out_q    <= out_d;
  end

  assign out_valid_o = out_valid_q;
  assign out_data_o  = out_q;

endmodule

`default_nettype wire

// File: hdl/imfs_checker.sv
// Port-level checker for the image mirror frame store, bound to the top.
// Depends on imfs_pkg and image_mirror_frame_store_assert.svh.
`default_nettype none
`include "image_mirror_frame_store_assert.svh"

module imfs_checker
  import imfs_pkg::*;
(
  input logic      clk_i,
  input logic      rst_ni,
  input logic      in_valid_i,
  input logic      in_ready_o,
  input logic      out_valid_o,
  input logic      out_ready_i,
  input imfs_out_t out_data_o,
  input logic      pready
);

  `IMFS_ASSERT_CLK(a_out_hold, clk_i, rst_ni, out_valid_o && !out_ready_i |=> out_valid_o && $stable(out_data_o), "result changed while stalled")
  `IMFS_ASSERT_CLK(a_one_in_flight, clk_i, rst_ni, in_valid_i && in_ready_o |=> !in_ready_o, "second item taken while one is in flight")
  `IMFS_ASSERT_CLK(a_err_zero, clk_i, rst_ni, out_valid_o && out_data_o.status |-> out_data_o.rd_value == '0, "error result carries nonzero data")
  `IMFS_ASSERT_CLK(a_no_early_result, clk_i, rst_ni, in_valid_i && in_ready_o |=> !$rose(out_valid_o), "result appeared right after input transaction")
  `IMFS_ASSERT_ALWAYS(a_pready, clk_i, pready, "pready dropped")

endmodule

bind image_mirror_frame_store imfs_checker u_imfs_checker (.*);

`default_nettype wire
